FILE: hdl/mode_latch_supervisor_macros.svh
// assertion macros used by the mode latch supervisor core (mls_core)
`ifndef MODE_LATCH_SUPERVISOR_MACROS_SVH
`define MODE_LATCH_SUPERVISOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MLS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MLS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/mls_pkg.sv
// types and constants of the mode latch supervisor
`timescale 1ns / 1ps

package mls_pkg;

	localparam int TIME_W = 32;
	localparam int CFG_W  = 16;
	localparam int MV_W   = 16;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_S1   = 2'd1,
		MODE_S2   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CLASS_OTHER    = 2'd0,
		CLASS_RUN      = 2'd1,
		CLASS_UPS      = 2'd2,
		CLASS_SHUTDOWN = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		REG_CONFIRM = 2'd0,
		REG_TROLLEY = 2'd1,
		REG_KEY     = 2'd2,
		REG_MAINS   = 2'd3
	} reg_idx_t;

	localparam logic [CFG_W-1:0] CONFIRM_RST = 16'd1000;
	localparam logic [CFG_W-1:0] TROLLEY_RST = 16'd2000;
	localparam logic [CFG_W-1:0] KEY_RST     = 16'd5000;
	localparam logic [CFG_W-1:0] MAINS_RST   = 16'd2200;

	typedef struct packed {
		logic [CFG_W-1:0] confirm_ms;
		logic [CFG_W-1:0] trolley_hold_ms;
		logic [CFG_W-1:0] key_reset_ms;
		logic [CFG_W-1:0] mains_threshold_mv;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              dip_s1;
		logic              dip_s2;
		logic              dip_solo;
		logic              reset_level;
		logic              onoff_level;
		logic              trolley_raw;
		logic              mains_flag;
		logic [MV_W-1:0]   pdc_mv;
		class_t            substate_class;
	} item_t;

	typedef struct packed {
		mode_t system_mode;
		logic  mode_locked;
		logic  solo_latched;
		mode_t enter_request;
		logic  error_indicate;
		logic  trolley_connected;
		logic  fan_on;
		logic  mains_led;
	} result_t;

endpackage

FILE: hdl/mls_core.sv
// supervisor state and the per-tick update logic
`timescale 1ns / 1ps
`include "mode_latch_supervisor_macros.svh"

module mls_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  mls_pkg::cfg_t    cfg,
	input  mls_pkg::item_t   item,
	output mls_pkg::result_t res
);

	mls_pkg::mode_t              mode_q, cand_mode_q;
	logic                        locked_q, cand_timing_q, solo_q, last_rst_q;
	logic                        last_shut_q, key_held_q, key_armed_q;
	logic                        troll_state_q, troll_timing_q;
	logic [mls_pkg::TIME_W-1:0]  cand_start_q, key_start_q, troll_start_q;

	mls_pkg::mode_t              mode_d, cand_mode_d;
	logic                        locked_d, cand_timing_d, solo_d;
	logic                        last_shut_d, key_held_d, key_armed_d;
	logic                        troll_state_d, troll_timing_d;
	logic [mls_pkg::TIME_W-1:0]  cand_start_d, key_start_d, troll_start_d;

	always_comb begin
		mls_pkg::mode_t want;
		mls_pkg::mode_t enter;
		logic           has_sub;
		logic           shut;
		logic           err;

		mode_d         = mode_q;
		cand_mode_d    = cand_mode_q;
		locked_d       = locked_q;
		cand_timing_d  = cand_timing_q;
		solo_d         = solo_q;
		last_shut_d    = last_shut_q;
		key_held_d     = key_held_q;
		key_armed_d    = key_armed_q;
		troll_state_d  = troll_state_q;
		troll_timing_d = troll_timing_q;
		cand_start_d   = cand_start_q;
		key_start_d    = key_start_q;
		troll_start_d  = troll_start_q;
		enter          = mls_pkg::MODE_NONE;
		err            = 1'b0;

		// reset input rising edge re-arms detection
		if (item.reset_level && !last_rst_q && locked_d) begin
			locked_d      = 1'b0;
			cand_mode_d   = mls_pkg::MODE_NONE;
			cand_timing_d = 1'b0;
		end

		if (item.dip_s1 && !item.dip_s2 && !item.dip_solo)
			want = mls_pkg::MODE_S1;
		else if (!item.dip_s1 && item.dip_s2)
			want = mls_pkg::MODE_S2;
		else
			want = mls_pkg::MODE_NONE;

		if (!locked_d) begin
			if (want != cand_mode_d || !cand_timing_d) begin
				cand_mode_d   = want;
				cand_timing_d = 1'b1;
				cand_start_d  = item.now_ms;
			end else if ((item.now_ms - cand_start_d) >= mls_pkg::TIME_W'(cfg.confirm_ms)) begin
				if (want != mode_q || (want == mls_pkg::MODE_S2 && item.dip_solo != solo_q))
					enter = want;
				mode_d   = want;
				solo_d   = item.dip_solo;
				locked_d = 1'b1;
			end
		end

		// trolley debounce
		if (!item.trolley_raw) begin
			troll_state_d  = 1'b0;
			troll_timing_d = 1'b0;
		end else if (!troll_state_d) begin
			if (!troll_timing_d) begin
				troll_timing_d = 1'b1;
				troll_start_d  = item.now_ms;
			end else if ((item.now_ms - troll_start_d)
					>= mls_pkg::TIME_W'(cfg.trolley_hold_ms)) begin
				troll_state_d = 1'b1;
			end
		end

		// key hold handling, only meaningful without a valid mode
		has_sub = (mode_d != mls_pkg::MODE_NONE);
		if (!has_sub) begin
			if (!locked_d) begin
				key_held_d  = 1'b0;
				key_armed_d = 1'b0;
			end else if (item.onoff_level && !key_held_d) begin
				key_held_d  = 1'b1;
				key_start_d = item.now_ms;
				key_armed_d = 1'b0;
			end else if (item.onoff_level && key_held_d) begin
				if ((item.now_ms - key_start_d) >= mls_pkg::TIME_W'(cfg.key_reset_ms))
					key_armed_d = 1'b1;
			end else if (!item.onoff_level && key_held_d) begin
				key_held_d = 1'b0;
				if (key_armed_d) begin
					key_armed_d   = 1'b0;
					locked_d      = 1'b0;
					cand_mode_d   = mls_pkg::MODE_NONE;
					cand_timing_d = 1'b0;
					last_shut_d   = 1'b0;
				end
			end
			err = locked_d;
		end

		// entry to shutdown re-arms detection
		shut = has_sub && (item.substate_class == mls_pkg::CLASS_SHUTDOWN);
		if (shut && !last_shut_d && locked_d) begin
			locked_d      = 1'b0;
			cand_mode_d   = mls_pkg::MODE_NONE;
			cand_timing_d = 1'b0;
		end
		last_shut_d = shut;

		res.system_mode       = mode_d;
		res.mode_locked       = locked_d;
		res.solo_latched      = solo_d;
		res.enter_request     = enter;
		res.error_indicate    = err;
		res.trolley_connected = troll_state_d;
		res.fan_on            = has_sub && (item.substate_class == mls_pkg::CLASS_RUN
			|| item.substate_class == mls_pkg::CLASS_UPS);
		res.mains_led         = item.mains_flag
			&& (item.pdc_mv > cfg.mains_threshold_mv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= mls_pkg::MODE_NONE;
			cand_mode_q    <= mls_pkg::MODE_NONE;
			locked_q       <= 1'b0;
			cand_timing_q  <= 1'b0;
			solo_q         <= 1'b0;
			last_rst_q     <= 1'b0;
			last_shut_q    <= 1'b0;
			key_held_q     <= 1'b0;
			key_armed_q    <= 1'b0;
			troll_state_q  <= 1'b0;
			troll_timing_q <= 1'b0;
			cand_start_q   <= '0;
			key_start_q    <= '0;
			troll_start_q  <= '0;
		end else if (fire) begin
			mode_q         <= mode_d;
			cand_mode_q    <= cand_mode_d;
			locked_q       <= locked_d;
			cand_timing_q  <= cand_timing_d;
			solo_q         <= solo_d;
			last_rst_q     <= item.reset_level;
			last_shut_q    <= last_shut_d;
			key_held_q     <= key_held_d;
			key_armed_q    <= key_armed_d;
			troll_state_q  <= troll_state_d;
			troll_timing_q <= troll_timing_d;
			cand_start_q   <= cand_start_d;
			key_start_q    <= key_start_d;
			troll_start_q  <= troll_start_d;
		end
	end

	// a latch on a shutdown entry tick re-arms at once, so only the mode is tied to enter
	`MLS_ASSERT_IMP(a_enter_locks, fire && res.enter_request != mls_pkg::MODE_NONE,
		res.enter_request == res.system_mode, "enter request for a mode other than the latched one")
	`MLS_ASSERT_IMP(a_err_mode, fire && res.error_indicate,
		res.mode_locked && res.system_mode == mls_pkg::MODE_NONE,
		"error indicator outside the latched error state")
	`MLS_ASSERT_NXT(a_key_clear, fire && !locked_d,
		!key_held_q && !key_armed_q || mode_q != mls_pkg::MODE_NONE,
		"key tracking active while unlocked without mode")
	`MLS_ASSERT_IMP(a_fan_mode, fire && res.fan_on, res.system_mode != mls_pkg::MODE_NONE,
		"fan on without a valid mode")

endmodule

FILE: hdl/mode_latch_supervisor.sv
// top level of the mode latch supervisor: config registers, input and result registers
`timescale 1ns / 1ps

// mode latch supervisor: each transfer on the input channel is one firmware tick
// (millisecond timestamp plus input levels) and yields exactly one result transfer.
// a tick is taken into an input register, the whole update runs in one pass of
// combinational logic in mls_core, and the result lands in an output register;
// the block sustains one tick per cycle while out_stall is low; the whole state
// update in mls_core (dip latch, trolley debounce, key hold timers) is in that pass.
// the output register frees as the result is taken, so a new tick is accepted in
// the same cycle that a waiting result transfers. configuration registers are
// written through cfg_we/cfg_index/cfg_data and should only change while idle.
module mode_latch_supervisor (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [mls_pkg::CFG_W-1:0]    cfg_data,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mls_pkg::TIME_W-1:0]   now_ms,
	input  logic                         dip_s1,
	input  logic                         dip_s2,
	input  logic                         dip_solo,
	input  logic                         reset_level,
	input  logic                         onoff_level,
	input  logic                         trolley_raw,
	input  logic                         mains_flag,
	input  logic [mls_pkg::MV_W-1:0]     pdc_mv,
	input  logic [1:0]                   substate_class,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   system_mode,
	output logic                         mode_locked,
	output logic                         solo_latched,
	output logic [1:0]                   enter_request,
	output logic                         error_indicate,
	output logic                         trolley_connected,
	output logic                         fan_on,
	output logic                         mains_led
);

	mls_pkg::cfg_t    cfg_q;
	mls_pkg::item_t   item_s1;
	logic             valid_s1;
	mls_pkg::result_t res_c;
	mls_pkg::result_t res_q;
	logic             out_valid_q;
	logic             fire;
	logic             in_take;

	// configuration registers, reset to their documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confirm_ms         <= mls_pkg::CONFIRM_RST;
			cfg_q.trolley_hold_ms    <= mls_pkg::TROLLEY_RST;
			cfg_q.key_reset_ms       <= mls_pkg::KEY_RST;
			cfg_q.mains_threshold_mv <= mls_pkg::MAINS_RST;
		end else if (cfg_we) begin
			case (mls_pkg::reg_idx_t'(cfg_index))
				mls_pkg::REG_CONFIRM: cfg_q.confirm_ms         <= cfg_data;
				mls_pkg::REG_TROLLEY: cfg_q.trolley_hold_ms    <= cfg_data;
				mls_pkg::REG_KEY:     cfg_q.key_reset_ms       <= cfg_data;
				mls_pkg::REG_MAINS:   cfg_q.mains_threshold_mv <= cfg_data;
				default: ;
			endcase
		end
	end

	// a tick in the input register is processed once the result register is free
	// or its content transfers in this cycle
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload register
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.now_ms         <= now_ms;
			item_s1.dip_s1         <= dip_s1;
			item_s1.dip_s2         <= dip_s2;
			item_s1.dip_solo       <= dip_solo;
			item_s1.reset_level    <= reset_level;
			item_s1.onoff_level    <= onoff_level;
			item_s1.trolley_raw    <= trolley_raw;
			item_s1.mains_flag     <= mains_flag;
			item_s1.pdc_mv         <= pdc_mv;
			item_s1.substate_class <= mls_pkg::class_t'(substate_class);
		end
	end

	// state and per-tick update
	mls_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cfg    (cfg_q),
		.item   (item_s1),
		.res    (res_c)
	);

	// result register, holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_c;
		end
	end

	assign out_valid         = out_valid_q;
	assign system_mode       = res_q.system_mode;
	assign mode_locked       = res_q.mode_locked;
	assign solo_latched      = res_q.solo_latched;
	assign enter_request     = res_q.enter_request;
	assign error_indicate    = res_q.error_indicate;
	assign trolley_connected = res_q.trolley_connected;
	assign fan_on            = res_q.fan_on;
	assign mains_led         = res_q.mains_led;

endmodule
